[rtl/ncbe_pkg.sv]
// ----------------------------------------------------------------------------
// ncbe_pkg
// Constants and helpers for the neighbour cell bucket enumerator.
// ----------------------------------------------------------------------------
package ncbe_pkg;

    localparam int HASH_BITS = 5;
    localparam int MAX_BINS  = 27;
    localparam int POS_W     = 24;
    localparam int BUCKET_W  = 15;
    localparam int AXES      = 3;

    // wrapped offsets -1 and +1 coincide only for a one-bit hash
    localparam logic [1:0] OFF_MAX = (HASH_BITS == 1) ? 2'd1 : 2'd2;

    localparam int CNT_W  = $clog2(MAX_BINS + 1);
    localparam int STEP_W = $clog2(POS_W);

    localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(MAX_BINS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(POS_W - 1);

    typedef logic [HASH_BITS-1:0] hash_t;

    // Morton interleave, x in the lowest bit of each triple, low bits kept
    function automatic logic [BUCKET_W-1:0] interleave3(hash_t bx, hash_t by, hash_t bz);
        logic [BUCKET_W-1:0] code;
        code = '0;
        for (int i = 0; i < HASH_BITS; i++)
        begin
            if (3 * i < BUCKET_W)
            begin
                code[3 * i] = bx[i];
            end
            if (3 * i + 1 < BUCKET_W)
            begin
                code[3 * i + 1] = by[i];
            end
            if (3 * i + 2 < BUCKET_W)
            begin
                code[3 * i + 2] = bz[i];
            end
        end
        return code;
    endfunction

endpackage

[rtl/neighbor_cell_bucket_enumerator.sv]
// ----------------------------------------------------------------------------
// neighbor_cell_bucket_enumerator
// Emits the distinct spatial-hash buckets of the 3x3x3 cells around a point.
// ----------------------------------------------------------------------------
// Division: three restoring dividers work bit-serially, one quotient bit per
//   cycle, then the buckets go out through the single output register.
// Throughput: one bucket per cycle while the sink is ready; a new position is
//   taken only in idle, after all N buckets (N = 27 here) of the last one.
// Reset: rst_n asynchronous, active low; cell_size returns to 1.0 (65536).
module neighbor_cell_bucket_enumerator
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,      // cell_size

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // pos_x[23:0], pos_y[47:24], pos_z[71:48]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // bucket[14:0], zero[15]
    output logic        m_axis_tlast   // is_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int PW = ncbe_pkg::POS_W;
    localparam int HB = ncbe_pkg::HASH_BITS;

    logic [1:0]                    state_reg, state_next;
    logic [ncbe_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [ncbe_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [1:0]                    ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic [PW-1:0]                 cell_size_reg;
    logic [PW-1:0]                 dvd_reg [ncbe_pkg::AXES];
    logic [PW-1:0]                 dvd_next [ncbe_pkg::AXES];
    logic [PW-1:0]                 rem_reg [ncbe_pkg::AXES];
    logic [PW-1:0]                 rem_next [ncbe_pkg::AXES];
    ncbe_pkg::hash_t               q_reg [ncbe_pkg::AXES];
    ncbe_pkg::hash_t               q_next [ncbe_pkg::AXES];
    logic                          ovalid_reg, ovalid_next;
    logic [ncbe_pkg::BUCKET_W-1:0] bucket_reg, bucket_next;
    logic                          last_reg, last_next;

    logic [PW-1:0]  divisor;
    logic [PW:0]    trial;
    logic           ge;
    logic           in_beat, out_free, cand_last;
    ncbe_pkg::hash_t bx, by, bz;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {1'b0, bucket_reg};
    assign m_axis_tlast  = last_reg;

    assign divisor  = (cell_size_reg == '0) ? PW'(1) : cell_size_reg;
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_free = !ovalid_reg || m_axis_tready;

    assign bx = q_reg[0] + HB'(ax_reg) - HB'(1);
    assign by = q_reg[1] + HB'(ay_reg) - HB'(1);
    assign bz = q_reg[2] + HB'(az_reg) - HB'(1);

    assign cand_last = ((ax_reg == ncbe_pkg::OFF_MAX) && (ay_reg == ncbe_pkg::OFF_MAX)
                        && (az_reg == ncbe_pkg::OFF_MAX)) || (cnt_reg == ncbe_pkg::LAST_CNT);

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        az_next     = az_reg;
        ovalid_next = ovalid_reg;
        bucket_next = bucket_reg;
        last_next   = last_reg;
        trial       = '0;
        ge          = 1'b0;
        for (int a = 0; a < ncbe_pkg::AXES; a++)
        begin
            dvd_next[a] = dvd_reg[a];
            rem_next[a] = rem_reg[a];
            q_next[a]   = q_reg[a];
        end

        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    for (int a = 0; a < ncbe_pkg::AXES; a++)
                    begin
                        dvd_next[a] = s_axis_tdata[a * PW +: PW];
                        rem_next[a] = '0;
                        q_next[a]   = '0;
                    end
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                for (int a = 0; a < ncbe_pkg::AXES; a++)
                begin
                    trial       = {rem_reg[a], dvd_reg[a][PW-1]};
                    ge          = (trial >= {1'b0, divisor});
                    rem_next[a] = ge ? PW'(trial - {1'b0, divisor}) : trial[PW-1:0];
                    dvd_next[a] = dvd_reg[a] << 1;
                    q_next[a]   = (q_reg[a] << 1) | HB'(ge);
                end
                step_next = step_reg + 1'b1;
                if (step_reg == ncbe_pkg::LAST_STEP)
                begin
                    cnt_next   = '0;
                    ax_next    = '0;
                    ay_next    = '0;
                    az_next    = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    bucket_next = ncbe_pkg::interleave3(bx, by, bz);
                    last_next   = cand_last;
                    cnt_next    = cnt_reg + 1'b1;
                    if (cand_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (az_reg != ncbe_pkg::OFF_MAX)
                    begin
                        az_next = az_reg + 1'b1;
                    end
                    else if (ay_reg != ncbe_pkg::OFF_MAX)
                    begin
                        az_next = '0;
                        ay_next = ay_reg + 1'b1;
                    end
                    else
                    begin
                        az_next = '0;
                        ay_next = '0;
                        ax_next = ax_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            az_reg        <= '0;
            ovalid_reg    <= 1'b0;
            cell_size_reg <= PW'(65536);
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
            ax_reg     <= ax_next;
            ay_reg     <= ay_next;
            az_reg     <= az_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready)
            begin
                cell_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < ncbe_pkg::AXES; a++)
        begin
            dvd_reg[a] <= dvd_next[a];
            rem_reg[a] <= rem_next[a];
            q_reg[a]   <= q_next[a];
        end
        bucket_reg <= bucket_next;
        last_reg   <= last_next;
    end

    // the x-axis remainder stays below the divisor after each divider step
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |=> (rem_reg[0] < divisor))
        else $error("divider remainder out of range");

    // never more buckets than the cap
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (cnt_reg < ncbe_pkg::CNT_W'(ncbe_pkg::MAX_BINS)))
        else $error("bucket count past cap");

    // a last beat loaded ends the item
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && cand_last) |=> (state_reg == ST_IDLE))
        else $error("emit did not end on last bucket");

    // the divider always hands over to emission after its full run
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && step_reg == ncbe_pkg::LAST_STEP) |=>
        (state_reg == ST_EMIT && cnt_reg == '0))
        else $error("divider end not followed by emission");

endmodule

[sim/ncbe_bucket_checker.sv]
// ----------------------------------------------------------------------------
// ncbe_bucket_checker
// Watches the cell size write channel and both streams of the neighbour cell
// bucket enumerator. It predicts the bucket beats of every accepted position
// and compares each output beat with the oldest one still expected.
// ----------------------------------------------------------------------------
module ncbe_bucket_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [23:0] cfg_data,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // pos_x[23:0], pos_y[47:24], pos_z[71:48]

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // bucket[14:0], zero[15]
    input  logic        m_axis_tlast,

    output int          errors,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int            PW         = ncbe_pkg::POS_W;
    localparam int            CODE_W     = 3 * ncbe_pkg::HASH_BITS;
    localparam logic [PW-1:0] CELL_RESET = 24'h010000;

    typedef struct packed
    {
        logic [ncbe_pkg::BUCKET_W-1:0] bucket;
        logic                          last;
    } bucket_beat_t;

    bucket_beat_t  expected_buckets[$];
    logic [PW-1:0] cell_len;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] bucket check: %s got 0x%0h, want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    task automatic predict_buckets(input logic [PW-1:0] px, input logic [PW-1:0] py,
                                   input logic [PW-1:0] pz);
        logic [PW-1:0]     divisor;
        logic [PW-1:0]     cidx[ncbe_pkg::AXES];
        ncbe_pkg::hash_t   wrapped[ncbe_pkg::AXES];
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] emitted[$];
        bit                dup;
        bucket_beat_t      beat;
        emitted.delete();
        // zero cell size divides by one LSB
        divisor = (cell_len == '0) ? PW'(1) : cell_len;
        cidx[0] = px / divisor;
        cidx[1] = py / divisor;
        cidx[2] = pz / divisor;
        for (int dx = 0; dx < 3; dx++)
        begin
            for (int dy = 0; dy < 3; dy++)
            begin
                for (int dz = 0; dz < 3; dz++)
                begin
                    wrapped[0] = ncbe_pkg::hash_t'(cidx[0] + PW'(dx) - PW'(1));
                    wrapped[1] = ncbe_pkg::hash_t'(cidx[1] + PW'(dy) - PW'(1));
                    wrapped[2] = ncbe_pkg::hash_t'(cidx[2] + PW'(dz) - PW'(1));
                    code = '0;
                    for (int b = 0; b < ncbe_pkg::HASH_BITS; b++)
                    begin
                        code[3 * b]     = wrapped[0][b];
                        code[3 * b + 1] = wrapped[1][b];
                        code[3 * b + 2] = wrapped[2][b];
                    end
                    // duplicates are judged on the full code, before truncation
                    dup = 1'b0;
                    foreach (emitted[k])
                    begin
                        if (emitted[k] == code)
                        begin
                            dup = 1'b1;
                        end
                    end
                    if (!dup && emitted.size() < ncbe_pkg::MAX_BINS)
                    begin
                        emitted.push_back(code);
                    end
                end
            end
        end
        foreach (emitted[k])
        begin
            beat.bucket = ncbe_pkg::BUCKET_W'(emitted[k]);
            beat.last   = (k == emitted.size() - 1);
            expected_buckets.push_back(beat);
        end
    endtask

    task automatic check_beat();
        bucket_beat_t want;
        if (expected_buckets.size() == 0)
        begin
            report_mismatch("beat with nothing expected, tdata", 32'(m_axis_tdata), 32'd0);
        end
        else
        begin
            want = expected_buckets.pop_front();
            if (m_axis_tdata[ncbe_pkg::BUCKET_W-1:0] !== want.bucket)
            begin
                report_mismatch("bucket", 32'(m_axis_tdata[ncbe_pkg::BUCKET_W-1:0]),
                                32'(want.bucket));
            end
            if (m_axis_tdata[15:ncbe_pkg::BUCKET_W] !== '0)
            begin
                report_mismatch("tdata padding", 32'(m_axis_tdata[15:ncbe_pkg::BUCKET_W]),
                                32'd0);
            end
            if (m_axis_tlast !== want.last)
            begin
                report_mismatch("tlast", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_len = CELL_RESET;
            expected_buckets.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cell_len = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_buckets(s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tdata[71:48]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_beat();
            end
            outstanding <= expected_buckets.size();
        end
    end

endmodule

[sim/neighbor_cell_bucket_enumerator_tb.sv]
// ----------------------------------------------------------------------------
// neighbor_cell_bucket_enumerator_tb
// Drives positions and cell sizes into the bucket enumerator: a directed set
// covering axis extremes, wrap at both ends of the hash range and zero, unit
// and maximum cell sizes, then random positions under several cell sizes with
// random source gaps and sink back-pressure. A checker beside the block
// predicts and compares every bucket beat.
// ----------------------------------------------------------------------------
module neighbor_cell_bucket_enumerator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW               = ncbe_pkg::POS_W;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 30;
    localparam int RANDOM_PER_PHASE = 33;

    logic          clk           = 1'b0;
    logic          rst_n         = 1'b0;
    logic          cfg_valid     = 1'b0;
    logic [PW-1:0] cfg_data      = '0;
    logic          s_axis_tvalid = 1'b0;
    logic [71:0]   s_axis_tdata  = '0;
    logic          m_axis_tready = 1'b0;

    logic          cfg_ready;
    logic          s_axis_tready;
    logic          m_axis_tvalid;
    logic [15:0]   m_axis_tdata;
    logic          m_axis_tlast;

    int            errors;
    int            outstanding;
    int            idle_pct     = 0;
    int            stall_pct    = 0;
    int            quiet_cycles = 0;

    always #5 clk = ~clk;

    neighbor_cell_bucket_enumerator u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    ncbe_bucket_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("neighbor_cell_bucket_enumerator regression: fail");
            $finish;
        end
    end

    task automatic send_position(input logic [PW-1:0] px, input logic [PW-1:0] py,
                                 input logic [PW-1:0] pz);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pz, py, px};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cell_size(input logic [PW-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // biased towards cell boundaries and both ends of the range
    function automatic logic [PW-1:0] random_axis(input logic [PW-1:0] h);
        logic [47:0] near;
        near = 48'(h) * 48'($urandom_range(0, 300)) + 48'($urandom_range(0, 2)) - 48'd1;
        case ($urandom_range(0, 3))
            0:       return PW'($urandom);
            1:       return near[PW-1:0];
            2:       return PW'($urandom_range(0, 3));
            default: return 24'hFFFFFF - PW'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [PW-1:0] random_cell_size();
        case ($urandom_range(0, 3))
            0:       return PW'($urandom_range(1, 255));
            1:       return PW'($urandom_range(24'h00F000, 24'h011000));
            2:       return PW'($urandom);
            default: return PW'($urandom_range(24'h008000, 24'h040000));
        endcase
    endfunction

    initial
    begin
        logic [PW-1:0] h;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cell size 1.0 from reset
        send_position(24'h000000, 24'h000000, 24'h000000);
        send_position(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_position(24'h1F0000, 24'h200000, 24'h1FFFFF);
        send_position(24'h00FFFF, 24'h010000, 24'h5A5A5A);
        send_position(24'hAAAAAA, 24'h555555, 24'h0F0F0F);

        // zero cell size: index is the raw position
        write_cell_size(24'h000000);
        send_position(24'h000000, 24'h000001, 24'h000002);
        send_position(24'hFFFFFF, 24'h00001F, 24'h000020);
        send_position(24'h00001E, 24'hFFFFE0, 24'h7FFFFF);

        write_cell_size(24'hFFFFFF);
        send_position(24'hFFFFFF, 24'hFFFFFE, 24'h000000);
        send_position(24'h000000, 24'h000000, 24'hFFFFFF);

        write_cell_size(24'h000001);
        send_position(24'h123456, 24'hFEDCBA, 24'h00001F);
        send_position(24'h000020, 24'h00003F, 24'h000041);

        write_cell_size(24'h000003);
        send_position(24'h000002, 24'h000003, 24'h00005F);
        send_position(24'h000060, 24'hFFFFFF, 24'h000000);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 54;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 54;
                end
                default:
                begin
                    idle_pct  = 27;
                    stall_pct = 27;
                end
            endcase
            for (int setting = 0; setting < 2; setting++)
            begin
                h = random_cell_size();
                write_cell_size(h);
                repeat (RANDOM_PER_PHASE)
                begin
                    send_position(random_axis(h), random_axis(h), random_axis(h));
                end
            end
        end

        wait_drained();
        if (errors == 0)
            $display("neighbor_cell_bucket_enumerator regression: pass");
        else
            $display("neighbor_cell_bucket_enumerator regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/ncbe_pkg.sv
rtl/neighbor_cell_bucket_enumerator.sv
sim/ncbe_bucket_checker.sv
sim/neighbor_cell_bucket_enumerator_tb.sv
